/* sv/kps_pkg.sv */
// Shared types, codes and lookup tables for the 3x4 keypad scanner.
`timescale 1ns / 1ps

package kps_pkg;

	// Key codes
	localparam logic [3:0] CODE_STAR = 4'd10;
	localparam logic [3:0] CODE_HASH = 4'd11;
	localparam logic [3:0] CODE_NONE = 4'd12;

	// Operation codes carried on tuser
	localparam logic OP_SCAN  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Scan phases: even drives a column, odd samples the rows
	localparam logic [2:0] PHASE_FIRST = 3'd0;
	localparam logic [2:0] PHASE_LAST  = 3'd5;

	// Column outputs with no column selected
	localparam logic [2:0] DRIVE_IDLE = 3'b111;

	// One input beat
	typedef struct packed {
		logic       operation;
		logic [3:0] row_lines;
		logic       hold;
		logic [3:0] set_value;
	} item_t;

	// One result beat
	typedef struct packed {
		logic [2:0] column_drive;
		logic [3:0] key_code;
	} result_t;

	// Column drive pattern, low bit selects the column
	function automatic logic [2:0] col_drive(input logic [1:0] col);
		logic [2:0] d;
		unique case (col)
			2'd0:    d = 3'b110;
			2'd1:    d = 3'b101;
			2'd2:    d = 3'b011;
			default: d = DRIVE_IDLE;
		endcase
		return d;
	endfunction

	// Key at a column and row, rows top to bottom
	function automatic logic [3:0] key_at(input logic [1:0] col, input logic [1:0] row);
		logic [3:0] k;
		unique case ({col, row})
			4'b00_00: k = 4'd1;
			4'b00_01: k = 4'd4;
			4'b00_10: k = 4'd7;
			4'b00_11: k = CODE_STAR;
			4'b01_00: k = 4'd2;
			4'b01_01: k = 4'd5;
			4'b01_10: k = 4'd8;
			4'b01_11: k = 4'd0;
			4'b10_00: k = 4'd3;
			4'b10_01: k = 4'd6;
			4'b10_10: k = 4'd9;
			4'b10_11: k = CODE_HASH;
			default:  k = CODE_NONE;
		endcase
		return k;
	endfunction

endpackage

/* sv/kps_core.sv */
// Scanner state and its registered update for each input beat.
`timescale 1ns / 1ps

module kps_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  kps_pkg::item_t   item,
	output kps_pkg::result_t result
);

	logic [2:0] phase_q;
	logic [2:0] col_q;
	logic       held_q;
	logic [3:0] pressed_q;
	logic [3:0] result_q;

	logic [2:0] phase_d;
	logic [2:0] col_d;
	logic       held_d;
	logic [3:0] pressed_d;
	logic [3:0] result_d;

	logic [2:0] ph;
	logic [1:0] col;
	logic       any_low;
	logic [1:0] row;
	logic       hit;
	logic       none;
	logic [3:0] key;

	// Fold unreachable phases onto the first one
	assign ph  = (phase_q > kps_pkg::PHASE_LAST) ? kps_pkg::PHASE_FIRST : phase_q;
	assign col = ph[2:1];

	// Pick the topmost low row
	always_comb begin
		any_low = ~&item.row_lines;
		priority if (!item.row_lines[0]) begin
			row = 2'd0;
		end else if (!item.row_lines[1]) begin
			row = 2'd1;
		end else if (!item.row_lines[2]) begin
			row = 2'd2;
		end else begin
			row = 2'd3;
		end
	end

	assign hit  = ph[0] & any_low;
	assign none = ph[0] & ~any_low & (ph == kps_pkg::PHASE_LAST);
	assign key  = kps_pkg::key_at(col, row);

	// Next state for this beat
	always_comb begin
		phase_d   = phase_q;
		col_d     = col_q;
		held_d    = held_q;
		pressed_d = pressed_q;
		result_d  = result_q;
		if (item.operation == kps_pkg::OP_WRITE) begin
			result_d = (item.set_value > kps_pkg::CODE_NONE) ? kps_pkg::CODE_NONE
			                                                 : item.set_value;
		end else if (!item.hold) begin
			if (!ph[0]) begin
				col_d   = kps_pkg::col_drive(col);
				phase_d = ph + 3'd1;
			end else if (hit || none) begin
				phase_d = kps_pkg::PHASE_FIRST;
			end else begin
				phase_d = ph + 3'd1;
			end
			// Latch on press, publish on release
			if (!held_q && hit) begin
				pressed_d = key;
				result_d  = kps_pkg::CODE_NONE;
				held_d    = 1'b1;
			end else if (held_q && none) begin
				held_d   = 1'b0;
				result_d = pressed_q;
			end
		end
	end

	// Commit the update when the beat moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= kps_pkg::PHASE_FIRST;
			col_q     <= kps_pkg::DRIVE_IDLE;
			held_q    <= 1'b0;
			pressed_q <= kps_pkg::CODE_NONE;
			result_q  <= kps_pkg::CODE_NONE;
		end else if (en) begin
			phase_q   <= phase_d;
			col_q     <= col_d;
			held_q    <= held_d;
			pressed_q <= pressed_d;
			result_q  <= result_d;
		end
	end

	assign result.column_drive = col_d;
	assign result.key_code     = result_d;

endmodule

/* sv/matrix_keypad_scan_release.sv */
// Top level of the keypad scanner: input register, scan core, output register.
//
//   channel | dir | tdata (low bit up)                               | tuser
//   s_      | in  | row_lines[3:0] hold[4] set_value[8:5] zeros      | operation
//   m_      | out | column_drive[2:0] key_code[6:3] zero[7]          | -
//
// One beat per clock while the output is not stalled; each beat is registered
// in the input register, then the output register. The scan state updates as
// a beat passes between the two, so that loop sets the rate.
// Reset clears the scan state and the valid flags; the stored code restarts at none.
// A stalled output holds its beat; the input register still takes a beat
// whenever it is itself empty or the output register is empty or being drained.
`timescale 1ns / 1ps

module matrix_keypad_scan_release (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // row_lines[3:0], hold[4], set_value[8:5], zero[15:9]
	input  logic        s_tuser,  // operation[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // column_drive[2:0], key_code[6:3], zero[7]
);

	logic               valid_s1;
	kps_pkg::item_t     item_s1;
	logic               advance;
	kps_pkg::result_t   result;
	logic               out_valid_q;
	kps_pkg::result_t   out_q;

	// Move a beat on when the output register is free or draining
	assign advance  = ~out_valid_q | m_tready;
	assign s_tready = ~valid_s1 | advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.operation <= s_tuser;
			item_s1.row_lines <= s_tdata[3:0];
			item_s1.hold      <= s_tdata[4];
			item_s1.set_value <= s_tdata[8:5];
		end
	end

	kps_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (valid_s1 & advance),
		.item   (item_s1),
		.result (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.key_code, out_q.column_drive};

`ifndef SYNTHESIS
	// At most one column is driven low
	a_one_column: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($countones(~m_tdata[2:0]) <= 1))
		else $error("more than one column driven");

	// Key code stays within the code range
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6:3] <= kps_pkg::CODE_NONE))
		else $error("key code out of range");

	// An empty output register never blocks the input side
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// A beat in the input register reaches the output in the next cycle when free
	a_forward: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (!m_tvalid || m_tready)) |=> m_tvalid)
		else $error("beat lost between stages");
`endif

endmodule

/* tb/sv/tb_matrix_keypad_scan_release.sv */
// Self-checking stream testbench for the 3x4 keypad scanner with release reporting.
`timescale 1ns / 1ps

module tb_matrix_keypad_scan_release;

	// Stimulus beat with pacing hints for the driver
	typedef struct {
		kps_pkg::item_t beat;
		bit             drain_first;
		bit             steady;
	} stim_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // row_lines[3:0], hold[4], set_value[8:5], zero[15:9]
	logic        s_tuser = 1'b0; // operation[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // column_drive[2:0], key_code[6:3], zero[7]

	stim_t            stim_q[$];
	kps_pkg::result_t due_results[$];
	int               n_items = 0;
	int               n_errors = 0;
	bit               s_took = 1'b0;
	bit               steady = 1'b0;

	// Scanner image: phase, column outputs, press latch and published code
	logic [2:0] scan_ph = kps_pkg::PHASE_FIRST;
	logic [2:0] drive_img = kps_pkg::DRIVE_IDLE;
	bit         held_img = 1'b0;
	logic [3:0] pressed_img = kps_pkg::CODE_NONE;
	logic [3:0] code_img = kps_pkg::CODE_NONE;

	// Key per column and row, indexed by col*4+row, top row first
	localparam logic [47:0] KEY_MAP = {kps_pkg::CODE_HASH, 4'd9, 4'd6, 4'd3,
		4'd0, 4'd8, 4'd5, 4'd2, kps_pkg::CODE_STAR, 4'd7, 4'd4, 4'd1};

	matrix_keypad_scan_release DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Advance the scanner image by one beat and return the expected output beat
	function automatic kps_pkg::result_t keypad_step(input kps_pkg::item_t it);
		logic [2:0]       ph;
		logic [1:0]       col;
		logic [3:0]       key;
		bit               hit;
		bit               scan_clear;
		kps_pkg::result_t res;
		hit = 1'b0;
		scan_clear = 1'b0;
		key = kps_pkg::CODE_NONE;
		if (it.operation == kps_pkg::OP_WRITE) begin
			code_img = (it.set_value > kps_pkg::CODE_NONE) ? kps_pkg::CODE_NONE
			                                               : it.set_value;
		end else if (!it.hold) begin
			ph = (scan_ph > kps_pkg::PHASE_LAST) ? kps_pkg::PHASE_FIRST : scan_ph;
			col = ph[2:1];
			if (!ph[0]) begin
				drive_img = ~(3'b001 << col);
				scan_ph = ph + 3'd1;
			end else begin
				// walk bottom-up so the top row wins
				for (int row = 3; row >= 0; row--) begin
					if (!it.row_lines[row]) begin
						hit = 1'b1;
						key = KEY_MAP[(col * 4 + row) * 4 +: 4];
					end
				end
				if (hit) begin
					scan_ph = kps_pkg::PHASE_FIRST;
				end else if (ph == kps_pkg::PHASE_LAST) begin
					scan_ph = kps_pkg::PHASE_FIRST;
					scan_clear = 1'b1;
				end else begin
					scan_ph = ph + 3'd1;
				end
			end
			if (hit && !held_img) begin
				pressed_img = key;
				code_img = kps_pkg::CODE_NONE;
				held_img = 1'b1;
			end else if (scan_clear && held_img) begin
				held_img = 1'b0;
				code_img = pressed_img;
			end
		end
		res.column_drive = drive_img;
		res.key_code = code_img;
		return res;
	endfunction

	task automatic add_beat(input logic op, input logic [3:0] rows, input logic hold,
			input logic [3:0] setv);
		stim_t s;
		s.beat.operation = op;
		s.beat.row_lines = rows;
		s.beat.hold = hold;
		s.beat.set_value = setv;
		// hold off until the pipe drains at a few points
		s.drain_first = (n_items == 28) || (n_items == 1000) || (n_items == 1500);
		s.steady = (n_items >= 600) && (n_items < 900);
		stim_q.push_back(s);
		n_items++;
	endtask

	// Drive the input stream at the falling edge
	always @(negedge clk) begin
		bit    load;
		stim_t nxt;
		if (arst_n && (!s_tvalid || s_took)) begin
			load = 1'b0;
			if (stim_q.size() != 0) begin
				load = !(stim_q[0].drain_first && due_results.size() != 0);
				if (load && !stim_q[0].steady && $urandom_range(0, 99) < 36)
					load = 1'b0;
			end
			if (load) begin
				nxt = stim_q.pop_front();
				steady <= nxt.steady;
				s_tdata <= {7'b0, nxt.beat.set_value, nxt.beat.hold, nxt.beat.row_lines};
				s_tuser <= nxt.beat.operation;
			end
			s_tvalid <= load;
		end
	end

	// Stall the output stream at random outside the steady stretch
	always @(negedge clk) begin
		if (arst_n)
			m_tready <= steady || ($urandom_range(0, 99) >= 36);
	end

	// Check output beats against the image, then predict accepted input beats
	always @(posedge clk) begin
		kps_pkg::result_t got;
		kps_pkg::result_t want;
		kps_pkg::item_t   it;
		if (arst_n) begin
			s_took <= s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				got.column_drive = m_tdata[2:0];
				got.key_code = m_tdata[6:3];
				if (due_results.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("unexpected beat: drive %b code %0d", got.column_drive,
							got.key_code);
				end else begin
					want = due_results.pop_front();
					if (got.column_drive != want.column_drive ||
							got.key_code != want.key_code) begin
						n_errors++;
						if (n_errors <= 10)
							$display("mismatch: drive exp %b got %b, code exp %0d got %0d",
								want.column_drive, got.column_drive, want.key_code,
								got.key_code);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				it.operation = s_tuser;
				it.row_lines = s_tdata[3:0];
				it.hold = s_tdata[4];
				it.set_value = s_tdata[8:5];
				due_results.push_back(keypad_step(it));
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int kind;
		int len;
		logic [3:0] rows;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// frozen tick at reset, then software writes including clamped values
		add_beat(kps_pkg::OP_SCAN, 4'h0, 1'b1, 4'hF);
		add_beat(kps_pkg::OP_WRITE, 4'hF, 1'b0, 4'd15);
		add_beat(kps_pkg::OP_WRITE, 4'h0, 1'b1, 4'd0);
		add_beat(kps_pkg::OP_WRITE, 4'hA, 1'b0, 4'd13);
		// press on the first column with every row low: top row wins
		add_beat(kps_pkg::OP_SCAN, 4'hF, 1'b0, 4'd0);
		add_beat(kps_pkg::OP_SCAN, 4'h0, 1'b0, 4'd7);
		// second key while held is ignored; a write changes only the code
		add_beat(kps_pkg::OP_SCAN, 4'hF, 1'b0, 4'd0);
		add_beat(kps_pkg::OP_SCAN, 4'h7, 1'b0, 4'd0);
		add_beat(kps_pkg::OP_WRITE, 4'h5, 1'b0, 4'd5);
		// clean scan with a frozen tick in the middle: release publishes the key
		add_beat(kps_pkg::OP_SCAN, 4'hF, 1'b0, 4'd0);
		add_beat(kps_pkg::OP_SCAN, 4'hF, 1'b0, 4'd0);
		add_beat(kps_pkg::OP_SCAN, 4'hF, 1'b0, 4'd0);
		add_beat(kps_pkg::OP_SCAN, 4'h0, 1'b1, 4'd0);
		add_beat(kps_pkg::OP_SCAN, 4'hF, 1'b0, 4'd0);
		add_beat(kps_pkg::OP_SCAN, 4'hF, 1'b0, 4'd0);
		add_beat(kps_pkg::OP_SCAN, 4'hF, 1'b0, 4'd0);
		// bottom row on the third column, then release
		for (int i = 0; i < 5; i++)
			add_beat(kps_pkg::OP_SCAN, 4'hF, 1'b0, 4'd12);
		add_beat(kps_pkg::OP_SCAN, 4'h7, 1'b0, 4'd12);
		for (int i = 0; i < 6; i++)
			add_beat(kps_pkg::OP_SCAN, 4'hF, 1'b0, 4'd12);

		// keystrokes with random content, some noise and write bursts
		while (n_items < 1700) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				if ($urandom_range(0, 3) != 0)
					rows = ~(4'b0001 << $urandom_range(0, 3));
				else
					rows = 4'($urandom_range(0, 14));
				len = $urandom_range(2, 8);
				for (int i = 0; i < len; i++)
					add_beat(($urandom_range(0, 19) == 0) ? kps_pkg::OP_WRITE
						: kps_pkg::OP_SCAN, rows,
						$urandom_range(0, 9) == 0, 4'($urandom_range(0, 15)));
				len = $urandom_range(6, 14);
				for (int i = 0; i < len; i++)
					add_beat(($urandom_range(0, 19) == 0) ? kps_pkg::OP_WRITE
						: kps_pkg::OP_SCAN, 4'hF,
						$urandom_range(0, 9) == 0, 4'($urandom_range(0, 15)));
			end else if (kind < 9) begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					add_beat(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
						1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
			end else begin
				len = $urandom_range(1, 3);
				for (int i = 0; i < len; i++)
					add_beat(kps_pkg::OP_WRITE, 4'($urandom_range(0, 15)),
						1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
			end
		end

		while (stim_q.size() != 0 || s_tvalid || due_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (due_results.size() != 0)
			n_errors += due_results.size();
		if (n_errors == 0)
			$display("** matrix_keypad_scan_release: PASSED **");
		else
			$display("** matrix_keypad_scan_release: FAILED **");
		$finish;
	end

	// Stop a hung run
	initial begin
		#400000;
		$display("** matrix_keypad_scan_release: FAILED **");
		$finish;
	end

endmodule
